// ===== hw/rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, types and helpers of the fragment sender.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

	localparam int SLOTS          = 32;
	localparam int SLOT_W         = 5;
	localparam int FRAG_BYTES     = 1024;
	localparam int FB_W           = $clog2(FRAG_BYTES);
	localparam int MAX_FRAGS      = 4096;
	localparam int FRAG_W         = $clog2(MAX_FRAGS);
	localparam int LANES          = 64;
	localparam int LANE_W         = $clog2(LANES);
	localparam int WORDS_PER_SLOT = MAX_FRAGS / LANES;
	localparam int WIDX_W         = $clog2(WORDS_PER_SLOT);
	localparam int ADDR_W         = SLOT_W + WIDX_W;
	localparam int MEM_DEPTH      = SLOTS * WORDS_PER_SLOT;
	localparam int CNT_W          = FRAG_W + 1;
	localparam int OFF_W          = FRAG_W + FB_W;
	localparam int LEN_W          = FB_W + 1;
	localparam int TOT_W          = OFF_W + 1;
	localparam int SIZE_W         = 24;
	localparam int ID_W           = 16;
	localparam int TIME_W         = 32;
	localparam int RES_W          = 13;
	localparam int TMO_W          = 20;
	localparam int BURST_W        = 7;
	localparam int CFG_W          = 20;
	localparam int CFG_A_W        = 2;
	localparam int ACT_W          = 3;
	localparam int KIND_W         = 3;
	localparam int ACKW_W         = 6;
	localparam int NSEND_W        = LANE_W + 1;

	localparam logic [CFG_A_W-1:0] CFG_RESEND  = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_BURST   = 2'd2;

	localparam logic [ACT_W-1:0] ACT_BEGIN  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLRALL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ACK    = 3'd4;

	localparam logic [KIND_W-1:0] K_ACCEPT  = 3'd0;
	localparam logic [KIND_W-1:0] K_REFUSE  = 3'd1;
	localparam logic [KIND_W-1:0] K_SEND    = 3'd2;
	localparam logic [KIND_W-1:0] K_TIMEOUT = 3'd3;
	localparam logic [KIND_W-1:0] K_GONE    = 3'd4;
	localparam logic [KIND_W-1:0] K_DONE    = 3'd5;
	localparam logic [KIND_W-1:0] K_IGNORE  = 3'd6;
	localparam logic [KIND_W-1:0] K_IDLE    = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC, ST_CLR, ST_TRD, ST_TEV, ST_TSCAN, ST_TFIN,
		ST_ARD, ST_AMSK, ST_ACNT1, ST_ACNT2, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [FRAG_W-1:0] frag;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic [ID_W-1:0]   tid;
		logic [ID_W-1:0]   tnr;
		logic [TOT_W-1:0]  total;
		logic [CNT_W-1:0]  acked;
		logic              last;
	} res_t;

	// shared lane control
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic [ADDR_W-1:0] wr_addr;
		logic [TIME_W-1:0] now;
		logic [RES_W-1:0]  resend;
	} lane_ctl_t;

	// lanes whose fragment index lies below the fragment count
	function automatic logic [LANES-1:0] lim_mask(input logic [WIDX_W-1:0] w,
			input logic [CNT_W-1:0] fc);
		logic [LANES-1:0] m;
		for (int j = 0; j < LANES; j++) begin
			m[j] = {1'b0, w, LANE_W'(j)} < fc;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfs_lane.sv =====
// ----------------------------------------------------------------------------
// sfs_lane
// One fragment lane: send-time store and resend eligibility check.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_lane import sfs_pkg::*; (
	input  wire logic      clk,
	input  wire lane_ctl_t ctl,
	input  wire logic      wr_en,
	input  wire logic      acked_bit,
	input  wire logic      valid_bit,
	input  wire logic      lim_bit,
	output logic           elig
);

	logic [TIME_W-1:0] time_mem [MEM_DEPTH];
	logic [TIME_W-1:0] rd_q;
	logic [TIME_W-1:0] age;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[ctl.wr_addr] <= ctl.now;
		end
		if (ctl.rd_en) begin
			rd_q <= time_mem[ctl.rd_addr];
		end
	end

	assign age  = ctl.now - rd_q;
	assign elig = lim_bit & ~acked_bit & ~(valid_bit & (age < {19'd0, ctl.resend}));

endmodule

`default_nettype wire

// ===== hw/rtl/sfs_pick.sv =====
// ----------------------------------------------------------------------------
// sfs_pick
// Merge of lane results: lowest eligible lane.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_pick import sfs_pkg::*; (
	input  wire logic [LANES-1:0]  mask,
	output logic                   found,
	output logic [LANE_W-1:0]      idx
);

	always_comb begin
		idx = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			if (mask[j]) idx = LANE_W'(j);
		end
	end

	assign found = |mask;

endmodule

`default_nettype wire

// ===== hw/rtl/selective_repeat_fragment_sender.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_fragment_sender
// Selective-repeat sender: slot table, 64 fragment lanes, ack bitmap merge.
// ----------------------------------------------------------------------------
// Sequence: cancel, clear-all and refused begins emit their result directly;
//   a begin first wipes the marks of the slot's 64 words; an ack reads, merges
//   and counts its word; a tick scans the words of up to 4096 fragments in turn.
// Throughput: one item at a time; the word scan over the mark memories sets it.
// Reset: slots idle, config at 250 / 45000 / 64; mark and time memories are
//   not cleared (each begin wipes its own slot's marks).
`default_nettype none

module selective_repeat_fragment_sender import sfs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// slot[4:0] now[36:5] transfer_size[60:37] transfer_id[76:61]
	// transfer_nr[92:77] client_alive[93] ack_present[94]
	// ack_word_index[100:95] ack_bits[164:101], zero pad above
	input  wire logic [167:0]       s_tdata,
	// action[2:0]
	input  wire logic [ACT_W-1:0]   s_tuser,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// out_slot[4:0] fragment_index[16:5] byte_offset[38:17] byte_length[49:39]
	// out_transfer_id[65:50] out_transfer_nr[81:66] total_size[104:82]
	// acked_count[117:105], zero pad above
	output logic [119:0]            m_tdata,
	// kind[2:0]
	output logic [KIND_W-1:0]       m_tuser,
	output logic                    m_tlast,
	input  wire logic               cfg_we,
	input  wire logic [CFG_A_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	// configuration
	logic [RES_W-1:0]   resend_q;
	logic [TMO_W-1:0]   timeout_q;
	logic [BURST_W-1:0] burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_q  <= RES_W'(250);
			timeout_q <= TMO_W'(45000);
			burst_q   <= BURST_W'(64);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RESEND:  resend_q  <= cfg_data[RES_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				CFG_BURST:   burst_q   <= cfg_data[BURST_W-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [ACT_W-1:0]  act_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] now_q;
	logic [SIZE_W-1:0] size_q;
	logic [ID_W-1:0]   tid_q;
	logic [ID_W-1:0]   tnr_q;
	logic              alive_q;
	logic              present_q;
	logic [ACKW_W-1:0] word_q;
	logic [LANES-1:0]  bits_q;

	// slot table
	logic [SLOTS-1:0]  slot_active_q;
	logic [TOT_W-1:0]  slot_bytes_q  [SLOTS];
	logic [CNT_W-1:0]  slot_fc_q     [SLOTS];
	logic [CNT_W-1:0]  slot_ack_q    [SLOTS];
	logic [ID_W-1:0]   slot_tid_q    [SLOTS];
	logic [ID_W-1:0]   slot_tnr_q    [SLOTS];
	logic [TIME_W-1:0] slot_start_q  [SLOTS];

	// per-word acked / sent marks, 64 fragments a word
	logic [LANES-1:0]  acked_mem [MEM_DEPTH];
	logic [LANES-1:0]  valid_mem [MEM_DEPTH];
	logic [LANES-1:0]  acked_rd_q;
	logic [LANES-1:0]  valid_rd_q;

	state_t state_q, state_d;

	logic [NSEND_W-1:0] w_q;
	logic [NSEND_W-1:0] n_q;
	logic [WIDX_W-1:0]  clr_q;
	logic [LANES-1:0]   mask_q;
	logic [LANES-1:0]   vword_q;
	logic [LANES-1:0]   newbits_s1;
	logic [3:0]         part_s2 [8];
	res_t               hold_q;
	logic               hold_v_q;
	res_t               out_q;
	logic               out_v_q;

	// current slot view
	logic              cur_act;
	logic [TOT_W-1:0]  cur_bytes;
	logic [CNT_W-1:0]  cur_fc;
	logic [CNT_W-1:0]  cur_ack;
	logic [ID_W-1:0]   cur_tid;
	logic [ID_W-1:0]   cur_tnr;
	logic [TIME_W-1:0] cur_start;

	assign cur_act   = slot_active_q[slot_q];
	assign cur_bytes = slot_bytes_q[slot_q];
	assign cur_fc    = slot_fc_q[slot_q];
	assign cur_ack   = slot_ack_q[slot_q];
	assign cur_tid   = slot_tid_q[slot_q];
	assign cur_tnr   = slot_tnr_q[slot_q];
	assign cur_start = slot_start_q[slot_q];

	// begin check: ceil(size / FRAG_BYTES)
	logic [SIZE_W:0]       sz_sum;
	logic [SIZE_W-FB_W:0]  frags;
	logic                  refuse;
	assign sz_sum = {1'b0, size_q} + (SIZE_W + 1)'(FRAG_BYTES - 1);
	assign frags  = sz_sum[SIZE_W:FB_W];
	assign refuse = (size_q == '0) || (frags > (SIZE_W - FB_W + 1)'(MAX_FRAGS));

	logic [TIME_W-1:0] elapsed;
	logic              timed_out;
	assign elapsed   = now_q - cur_start;
	assign timed_out = elapsed > {{(TIME_W - TMO_W){1'b0}}, timeout_q};

	logic [NSEND_W-1:0] limit;
	logic [NSEND_W-1:0] nwords;
	logic [CNT_W:0]     fc_up;
	assign limit  = (burst_q > BURST_W'(LANES)) ? NSEND_W'(LANES) : burst_q;
	assign fc_up  = {1'b0, cur_fc} + (CNT_W + 1)'(LANES - 1);
	// at most 64 words, so the top bit of the sum is never set
	assign nwords = fc_up[CNT_W-1:LANE_W];

	logic ack_match;
	assign ack_match = cur_act && (tnr_q == cur_tnr);
	logic [ID_W-1:0] tid_next;
	assign tid_next = cur_tid + ID_W'(1);

	// lanes and merge
	lane_ctl_t        lctl;
	logic [LANES-1:0] lane_wr;
	logic [LANES-1:0] elig;
	logic [LANES-1:0] lim_tick;
	logic [LANES-1:0] lim_ack;
	logic             pick_found;
	logic [LANE_W-1:0] pick_idx;

	assign lim_tick = lim_mask(w_q[WIDX_W-1:0], cur_fc);
	assign lim_ack  = lim_mask(word_q, cur_fc);

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		sfs_lane u_lane (
			.clk       (clk),
			.ctl       (lctl),
			.wr_en     (lane_wr[j]),
			.acked_bit (acked_rd_q[j]),
			.valid_bit (valid_rd_q[j]),
			.lim_bit   (lim_tick[j]),
			.elig      (elig[j])
		);
	end

	sfs_pick u_pick (
		.mask  (mask_q),
		.found (pick_found),
		.idx   (pick_idx)
	);

	logic can_load;
	assign can_load = !out_v_q || m_tready;

	logic send_go;
	assign send_go = pick_found && (n_q < limit);

	// row builders
	res_t slot_row;
	res_t zero_row;
	res_t send_row;
	logic [FRAG_W-1:0] send_frag;
	logic [TOT_W-1:0]  send_rest;

	always_comb begin
		slot_row       = '0;
		slot_row.slot  = slot_q;
		slot_row.tid   = cur_tid;
		slot_row.tnr   = cur_tnr;
		slot_row.total = cur_bytes;
		slot_row.acked = cur_ack;
		zero_row       = '0;
		zero_row.slot  = slot_q;
		send_frag      = {w_q[WIDX_W-1:0], pick_idx};
		send_row       = slot_row;
		send_row.kind  = K_SEND;
		send_row.frag  = send_frag;
		send_row.off   = {send_frag, {FB_W{1'b0}}};
		send_rest      = cur_bytes - {1'b0, send_row.off};
		send_row.len   = (send_rest > TOT_W'(FRAG_BYTES)) ? LEN_W'(FRAG_BYTES)
			: send_rest[LEN_W-1:0];
	end

	// single-result row decided at decode
	res_t dec_row;
	always_comb begin
		dec_row      = cur_act ? slot_row : zero_row;
		dec_row.kind = K_IGNORE;
		case (act_q)
			ACT_BEGIN: begin
				dec_row       = zero_row;
				dec_row.kind  = refuse ? K_REFUSE : K_ACCEPT;
				dec_row.tid   = tid_q;
				dec_row.tnr   = tnr_q;
				dec_row.total = refuse ? '0 : size_q[TOT_W-1:0];
			end
			ACT_TICK: begin
				dec_row.kind = !cur_act ? K_IGNORE : !alive_q ? K_GONE
					: timed_out ? K_TIMEOUT : K_IDLE;
			end
			ACT_ACK: begin
				dec_row.kind = (ack_match && tid_q == tid_next) ? K_DONE : K_IGNORE;
			end
			ACT_CANCEL, ACT_CLRALL: begin
				dec_row      = zero_row;
				dec_row.kind = K_IGNORE;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DEC;
			ST_DEC: begin
				case (act_q)
					ACT_BEGIN: state_d = refuse ? ST_EMIT : ST_CLR;
					ACT_TICK:  state_d = (cur_act && alive_q && !timed_out) ? ST_TRD : ST_EMIT;
					ACT_ACK:   state_d = (ack_match && tid_q != tid_next && tid_q == cur_tid
						&& present_q) ? ST_ARD : ST_EMIT;
					default:   state_d = ST_EMIT;
				endcase
			end
			ST_CLR:   if (clr_q == '1) state_d = ST_EMIT;
			ST_TRD:   state_d = (w_q == nwords || n_q == limit) ? ST_TFIN : ST_TEV;
			ST_TEV:   state_d = ST_TSCAN;
			ST_TSCAN: if (!send_go) state_d = ST_TRD;
			ST_TFIN:  state_d = ST_EMIT;
			ST_ARD:   state_d = ST_AMSK;
			ST_AMSK:  state_d = ST_ACNT1;
			ST_ACNT1: state_d = ST_ACNT2;
			ST_ACNT2: state_d = ST_EMIT;
			ST_EMIT:  if (can_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	logic              mem_rd;
	logic [ADDR_W-1:0] mem_addr;
	logic              acked_we;
	logic              valid_we;
	logic [LANES-1:0]  acked_wd;
	logic [LANES-1:0]  valid_wd;
	logic              scan_take;

	always_comb begin
		mem_rd    = 1'b0;
		mem_addr  = {slot_q, w_q[WIDX_W-1:0]};
		acked_we  = 1'b0;
		valid_we  = 1'b0;
		acked_wd  = '0;
		valid_wd  = vword_q;
		lane_wr   = '0;
		scan_take = 1'b0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_CLR: begin
				mem_addr = {slot_q, clr_q};
				acked_we = 1'b1;
				valid_we = 1'b1;
				valid_wd = '0;
			end
			ST_TRD: mem_rd = (w_q != nwords) && (n_q != limit);
			ST_TSCAN: begin
				if (send_go) begin
					// a held send leaves only when the output can take it
					scan_take = !hold_v_q || can_load;
					lane_wr[pick_idx] = scan_take;
				end else begin
					valid_we = 1'b1;
				end
			end
			ST_ARD: begin
				mem_rd   = 1'b1;
				mem_addr = {slot_q, word_q};
			end
			ST_AMSK: begin
				mem_addr = {slot_q, word_q};
				acked_we = 1'b1;
				acked_wd = acked_rd_q | (bits_q & lim_ack);
			end
			default: ;
		endcase
	end

	always_comb begin
		lctl.rd_en   = mem_rd;
		lctl.rd_addr = mem_addr;
		lctl.wr_addr = {slot_q, w_q[WIDX_W-1:0]};
		lctl.now     = now_q;
		lctl.resend  = resend_q;
	end

	always_ff @(posedge clk) begin
		if (acked_we) acked_mem[mem_addr] <= acked_wd;
		if (valid_we) valid_mem[mem_addr] <= valid_wd;
		if (mem_rd) begin
			acked_rd_q <= acked_mem[mem_addr];
			valid_rd_q <= valid_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// item capture, slot table payload, scan datapath
	logic [NSEND_W-1:0] pop_sum;
	always_comb begin
		pop_sum = '0;
		for (int k = 0; k < 8; k++) pop_sum = pop_sum + NSEND_W'(part_s2[k]);
	end

	// ack result with the updated count
	logic [CNT_W-1:0] ack_sum;
	res_t             ack_row;
	assign ack_sum = cur_ack + CNT_W'(pop_sum);
	always_comb begin
		ack_row       = slot_row;
		ack_row.kind  = K_ACCEPT;
		ack_row.acked = ack_sum;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			act_q     <= s_tuser;
			slot_q    <= s_tdata[4:0];
			now_q     <= s_tdata[36:5];
			size_q    <= s_tdata[60:37];
			tid_q     <= s_tdata[76:61];
			tnr_q     <= s_tdata[92:77];
			alive_q   <= s_tdata[93];
			present_q <= s_tdata[94];
			word_q    <= s_tdata[100:95];
			bits_q    <= s_tdata[164:101];
		end
		case (state_q)
			ST_DEC: begin
				clr_q  <= '0;
				w_q    <= '0;
				n_q    <= '0;
				hold_q <= dec_row;
				if (act_q == ACT_BEGIN && !refuse) begin
					slot_bytes_q[slot_q] <= size_q[TOT_W-1:0];
					slot_fc_q[slot_q]    <= frags[CNT_W-1:0];
					slot_ack_q[slot_q]   <= '0;
					slot_tid_q[slot_q]   <= tid_q;
					slot_tnr_q[slot_q]   <= tnr_q;
					slot_start_q[slot_q] <= now_q;
				end
			end
			ST_CLR: clr_q <= clr_q + WIDX_W'(1);
			ST_TEV: begin
				mask_q  <= elig;
				vword_q <= valid_rd_q;
			end
			ST_TSCAN: begin
				if (send_go) begin
					if (scan_take) begin
						hold_q <= send_row;
						mask_q[pick_idx]  <= 1'b0;
						vword_q[pick_idx] <= 1'b1;
						n_q <= n_q + NSEND_W'(1);
					end
				end else begin
					w_q <= w_q + NSEND_W'(1);
				end
			end
			ST_AMSK: newbits_s1 <= bits_q & lim_ack & ~acked_rd_q;
			ST_ACNT1: begin
				for (int k = 0; k < 8; k++) begin
					part_s2[k] <= 4'($countones(newbits_s1[8*k +: 8]));
				end
			end
			ST_ACNT2: begin
				slot_ack_q[slot_q] <= ack_sum;
				hold_q             <= ack_row;
			end
			default: ;
		endcase
	end

	// control flags: active marks, held-send valid, output register
	logic out_load;
	res_t out_d;
	always_comb begin
		out_load = 1'b0;
		out_d    = hold_q;
		if (state_q == ST_TSCAN && scan_take && hold_v_q) begin
			out_load = 1'b1;
			out_d.last = 1'b0;
		end else if (state_q == ST_EMIT && can_load) begin
			out_load = 1'b1;
			out_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q <= '0;
			hold_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if (state_q == ST_DEC) begin
				hold_v_q <= 1'b0;
				case (act_q)
					ACT_BEGIN:  if (!refuse) slot_active_q[slot_q] <= 1'b1;
					ACT_CANCEL: slot_active_q[slot_q] <= 1'b0;
					ACT_CLRALL: slot_active_q <= '0;
					ACT_TICK:   if (!alive_q || timed_out) slot_active_q[slot_q] <= 1'b0;
					ACT_ACK:    if (ack_match && tid_q == tid_next) slot_active_q[slot_q] <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == ST_TSCAN && scan_take) hold_v_q <= 1'b1;
			if (state_q == ST_EMIT && can_load) hold_v_q <= 1'b0;
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_d;
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {2'b00, out_q.acked, out_q.total, out_q.tnr, out_q.tid,
		out_q.len, out_q.off, out_q.frag, out_q.slot};

	// sends per tick never exceed the lane count
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NSEND_W'(LANES))
		else $error("send count beyond lane count");

	// a held send exists only while a tick is being worked or finished
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (state_q == ST_TRD || state_q == ST_TEV || state_q == ST_TSCAN
			|| state_q == ST_TFIN || state_q == ST_EMIT))
		else $error("held send outside tick");

	// a result loaded mid-scan is a send and not the final one
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TSCAN && out_load) |=> (out_q.kind == K_SEND && !out_q.last))
		else $error("mid-scan result malformed");

	// no new item is taken while a result is pending in the hold stage
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !can_load) |=> !s_tready)
		else $error("item accepted before final result");

endmodule

`default_nettype wire

// ===== tb/tb_selective_repeat_fragment_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_fragment_sender
// Drives begin, cancel, clear-all, tick and ack items into the fragment
// sender under random source gaps and sink stalls. A scoreboard keeps its own
// copy of the slot table and fragment marks and checks every result item.
// ----------------------------------------------------------------------------
module tb_selective_repeat_fragment_sender;
	import sfs_pkg::*;

	// one expected result item
	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [FRAG_W-1:0] frag;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic [ID_W-1:0]   tid;
		logic [ID_W-1:0]   tnr;
		logic [TOT_W-1:0]  total;
		logic [CNT_W-1:0]  acked;
		logic              last;
	} sched_res_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [167:0] s_tdata;
	logic [ACT_W-1:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [119:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we;
	logic [CFG_A_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_data;

	selective_repeat_fragment_sender u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// scoreboard copy of the sender's state
	logic [RES_W-1:0]   sb_resend;
	logic [TMO_W-1:0]   sb_timeout;
	logic [BURST_W-1:0] sb_burst;
	logic               sb_active [SLOTS];
	logic [TOT_W-1:0]   sb_bytes [SLOTS];
	logic [CNT_W-1:0]   sb_nfrags [SLOTS];
	logic [CNT_W-1:0]   sb_nacked [SLOTS];
	logic [ID_W-1:0]    sb_tid [SLOTS];
	logic [ID_W-1:0]    sb_tnr [SLOTS];
	logic [TIME_W-1:0]  sb_start [SLOTS];
	logic               frag_held [SLOTS*MAX_FRAGS];
	logic               frag_was_sent [SLOTS*MAX_FRAGS];
	logic [TIME_W-1:0]  frag_sent_at [SLOTS*MAX_FRAGS];

	sched_res_t pending_res[$];
	int n_items, n_results, n_sends, n_errors;
	logic [TIME_W-1:0] clock_now;
	int burst_left;
	bit no_gaps;
	int hold_req;  // set by a test, counted down by the sink process

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout, %0d results still pending", pending_res.size());
		$display("tb_selective_repeat_fragment_sender: errors");
		$finish;
	end

	// --------------------------------------------------------------------
	// Scoreboard
	// --------------------------------------------------------------------
	task automatic push_res(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] sl,
			input int unsigned fi, input int unsigned off, input int unsigned len,
			input logic [ID_W-1:0] tid, input logic [ID_W-1:0] tnr,
			input logic [TOT_W-1:0] tot, input logic [CNT_W-1:0] ack);
		sched_res_t r;
		r.kind = k; r.slot = sl; r.frag = fi[FRAG_W-1:0]; r.off = off[OFF_W-1:0];
		r.len = len[LEN_W-1:0]; r.tid = tid; r.tnr = tnr; r.total = tot;
		r.acked = ack; r.last = 1'b0;
		pending_res.push_back(r);
	endtask

	task automatic push_slot_res(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] sl);
		push_res(k, sl, 0, 0, 0, sb_tid[sl], sb_tnr[sl], sb_bytes[sl], sb_nacked[sl]);
	endtask

	// works out the result items of one accepted item and updates the copy
	task automatic predict_sender(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] sl,
			input logic [TIME_W-1:0] now, input logic [SIZE_W-1:0] size,
			input logic [ID_W-1:0] tid, input logic [ID_W-1:0] tnr,
			input logic alive, input logic present, input logic [ACKW_W-1:0] word,
			input logic [63:0] bits);
		int unsigned base, nfr, lim, i, fi, len, n;
		base = sl * MAX_FRAGS;
		n = 0;
		if (act == ACT_BEGIN) begin
			nfr = (size + FRAG_BYTES - 1) / FRAG_BYTES;
			if (size == 0 || nfr > MAX_FRAGS) begin
				push_res(K_REFUSE, sl, 0, 0, 0, tid, tnr, 0, 0);
			end else begin
				sb_active[sl] = 1'b1;
				sb_bytes[sl] = size[TOT_W-1:0];
				sb_nfrags[sl] = nfr[CNT_W-1:0];
				sb_nacked[sl] = '0;
				sb_tid[sl] = tid;
				sb_tnr[sl] = tnr;
				sb_start[sl] = now;
				for (i = 0; i < MAX_FRAGS; i++) begin
					frag_held[base+i] = 1'b0;
					frag_was_sent[base+i] = 1'b0;
				end
				push_slot_res(K_ACCEPT, sl);
			end
		end else if (act == ACT_CANCEL) begin
			sb_active[sl] = 1'b0;
			push_res(K_IGNORE, sl, 0, 0, 0, 0, 0, 0, 0);
		end else if (act == ACT_CLRALL) begin
			for (i = 0; i < SLOTS; i++) sb_active[i] = 1'b0;
			push_res(K_IGNORE, sl, 0, 0, 0, 0, 0, 0, 0);
		end else if (act == ACT_TICK && sb_active[sl]) begin
			if (!alive) begin
				push_slot_res(K_GONE, sl);
				sb_active[sl] = 1'b0;
			end else if (TIME_W'(now - sb_start[sl]) > sb_timeout) begin
				push_slot_res(K_TIMEOUT, sl);
				sb_active[sl] = 1'b0;
			end else begin
				lim = (sb_burst > LANES) ? LANES : sb_burst;
				for (i = 0; i < sb_nfrags[sl] && n < lim; i++) begin
					fi = base + i;
					if (frag_held[fi]) continue;
					if (frag_was_sent[fi] && TIME_W'(now - frag_sent_at[fi]) < sb_resend)
						continue;
					len = sb_bytes[sl] - i * FRAG_BYTES;
					if (len > FRAG_BYTES) len = FRAG_BYTES;
					push_res(K_SEND, sl, i, i * FRAG_BYTES, len, sb_tid[sl], sb_tnr[sl],
						sb_bytes[sl], sb_nacked[sl]);
					frag_was_sent[fi] = 1'b1;
					frag_sent_at[fi] = now;
					n++;
				end
				if (n == 0) push_slot_res(K_IDLE, sl);
			end
		end else if (act == ACT_ACK && sb_active[sl] && tnr == sb_tnr[sl]) begin
			if (tid == ID_W'(sb_tid[sl] + 1)) begin
				push_slot_res(K_DONE, sl);
				sb_active[sl] = 1'b0;
			end else if (tid != sb_tid[sl] || !present) begin
				push_slot_res(K_IGNORE, sl);
			end else begin
				for (i = 0; i < LANES; i++) begin
					fi = word * LANES + i;
					if (fi >= sb_nfrags[sl]) break;
					if (bits[i] && !frag_held[base+fi]) begin
						frag_held[base+fi] = 1'b1;
						sb_nacked[sl]++;
					end
				end
				push_slot_res(K_ACCEPT, sl);
			end
		end else if (sb_active[sl]) begin
			push_slot_res(K_IGNORE, sl);
		end else begin
			push_res(K_IGNORE, sl, 0, 0, 0, 0, 0, 0, 0);
		end
		pending_res[pending_res.size()-1].last = 1'b1;
	endtask

	// checks each result item against the oldest expectation
	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (m_tuser == K_SEND) n_sends++;
			if (pending_res.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result kind %0d data %h", m_tuser, m_tdata);
			end else begin
				e = pending_res.pop_front();
				if (m_tuser !== e.kind || m_tdata[4:0] !== e.slot
						|| m_tdata[16:5] !== e.frag || m_tdata[38:17] !== e.off
						|| m_tdata[49:39] !== e.len || m_tdata[65:50] !== e.tid
						|| m_tdata[81:66] !== e.tnr || m_tdata[104:82] !== e.total
						|| m_tdata[117:105] !== e.acked || m_tlast !== e.last) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch exp kind %0d slot %0d frag %0d off %0d len %0d",
							e.kind, e.slot, e.frag, e.off, e.len);
						$display("  exp tid %h tnr %h total %0d acked %0d last %b",
							e.tid, e.tnr, e.total, e.acked, e.last);
						$display("  got kind %0d slot %0d frag %0d off %0d len %0d",
							m_tuser, m_tdata[4:0], m_tdata[16:5], m_tdata[38:17],
							m_tdata[49:39]);
						$display("  got tid %h tnr %h total %0d acked %0d last %b",
							m_tdata[65:50], m_tdata[81:66], m_tdata[104:82],
							m_tdata[117:105], m_tlast);
					end
				end
			end
		end
	end

	// sink: alternates free-running and random stall phases, plus long holds
	initial begin
		int phase_cnt;
		bit stall_phase;
		m_tready = 1'b0;
		phase_cnt = 0;
		stall_phase = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				m_tready = 1'b0;
				hold_req--;
			end else begin
				if (phase_cnt == 0) begin
					phase_cnt = $urandom_range(20, 300);
					stall_phase = $urandom_range(0, 2) != 0;
				end
				phase_cnt--;
				m_tready = stall_phase ? ($urandom_range(0, 99) < 60) : 1'b1;
			end
		end
	end

	// --------------------------------------------------------------------
	// Source side
	// --------------------------------------------------------------------
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] sl,
			input logic [TIME_W-1:0] now, input logic [SIZE_W-1:0] size,
			input logic [ID_W-1:0] tid, input logic [ID_W-1:0] tnr,
			input logic alive, input logic present, input logic [ACKW_W-1:0] word,
			input logic [63:0] bits);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tuser = act;
		s_tdata = {3'b0, bits, word, present, alive, tnr, tid, size, now, sl};
		s_tvalid = 1'b1;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		n_items++;
		predict_sender(act, sl, now, size, tid, tnr, alive, present, word, bits);
	endtask

	// waits for every result, then lets a walk of the largest tick finish
	task automatic drain_all();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_res.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_data = val[CFG_W-1:0];
		if (idx == CFG_RESEND) sb_resend = val[RES_W-1:0];
		else if (idx == CFG_TIMEOUT) sb_timeout = val[TMO_W-1:0];
		else if (idx == CFG_BURST) sb_burst = val[BURST_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(input int unsigned rs, input int unsigned to, input int unsigned bu);
		drain_all();
		write_reg(CFG_RESEND, rs);
		write_reg(CFG_TIMEOUT, to);
		write_reg(CFG_BURST, bu);
	endtask

	task automatic tick_now(input logic [SLOT_W-1:0] sl, input logic alive);
		send_item(ACT_TICK, sl, clock_now, $urandom, $urandom, $urandom, alive,
			$urandom, $urandom, {$urandom, $urandom});
	endtask

	// one random item, mostly well-formed traffic on a few busy slots
	task automatic random_item();
		logic [SLOT_W-1:0] sl;
		logic [SIZE_W-1:0] size;
		logic [ACKW_W-1:0] word;
		int r;
		sl = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, 7)) : SLOT_W'($urandom);
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 49) == 0) clock_now = $urandom;
		else clock_now += $urandom_range(0, 300);
		if (!sb_active[sl] && r < 70) r = 0;
		if (r < 10) begin
			case ($urandom_range(0, 39))
				0: size = SIZE_W'(MAX_FRAGS * FRAG_BYTES);
				1: size = SIZE_W'($urandom);
				2: size = 0;
				default: size = SIZE_W'($urandom_range(1, 20000));
			endcase
			send_item(ACT_BEGIN, sl, clock_now, size, $urandom, $urandom, $urandom,
				$urandom, $urandom, {$urandom, $urandom});
		end else if (r < 55) begin
			tick_now(sl, $urandom_range(0, 39) != 0);
		end else if (r < 85) begin
			word = ($urandom_range(0, 9) != 0) ? ACKW_W'(sb_nfrags[sl] / LANES)
				: ACKW_W'($urandom);
			send_item(ACT_ACK, sl, clock_now, $urandom, sb_tid[sl], sb_tnr[sl], $urandom,
				1'b1, word, {$urandom, $urandom} & {$urandom, $urandom});
		end else if (r < 88) begin
			send_item(ACT_ACK, sl, clock_now, $urandom, sb_tid[sl] + 1'b1, sb_tnr[sl],
				$urandom, $urandom, $urandom, {$urandom, $urandom});
		end else if (r < 92) begin
			case ($urandom_range(0, 2))
				0: send_item(ACT_ACK, sl, clock_now, $urandom, sb_tid[sl],
					sb_tnr[sl] ^ ID_W'($urandom_range(1, 65535)), $urandom, 1'b1, 0,
					{$urandom, $urandom});
				1: send_item(ACT_ACK, sl, clock_now, $urandom, sb_tid[sl] + 16'd2, sb_tnr[sl],
					$urandom, 1'b1, 0, {$urandom, $urandom});
				default: send_item(ACT_ACK, sl, clock_now, $urandom, sb_tid[sl], sb_tnr[sl],
					$urandom, 1'b0, 0, {$urandom, $urandom});
			endcase
		end else if (r < 95) begin
			send_item(ACT_CANCEL, sl, clock_now, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, {$urandom, $urandom});
		end else if (r < 96) begin
			send_item(ACT_CLRALL, sl, clock_now, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, {$urandom, $urandom});
		end else begin
			// undefined codes and fully random noise
			send_item(ACT_W'($urandom_range(0, 7)), sl, clock_now, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
		end
	endtask

	task automatic run_random(input int n);
		repeat (n) random_item();
	endtask

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------
	task automatic test_directed();
		logic [63:0] z;
		z = '0;
		clock_now = 32'd1000;
		send_item(ACT_BEGIN, 0, clock_now, 1, 16'h0001, 16'h0002, 1, 0, 0, z);
		send_item(ACT_BEGIN, 1, clock_now, MAX_FRAGS * FRAG_BYTES, 16'hFFFF, 16'hFFFF,
			1, 0, 0, z);
		send_item(ACT_BEGIN, 2, clock_now, 0, 16'h1234, 16'h5678, 1, 0, 0, z);
		send_item(ACT_BEGIN, 2, clock_now, MAX_FRAGS * FRAG_BYTES + 1, 0, 0, 1, 0, 0, z);
		send_item(ACT_BEGIN, 31, clock_now, 24'hFFFFFF, 16'hFFFF, 0, 1, 1, 63, '1);
		tick_now(0, 1);        // single one-byte fragment
		tick_now(0, 1);        // resend window not yet open: nothing sent
		tick_now(1, 1);        // full burst of 64
		send_item(ACT_ACK, 1, clock_now, 0, 16'hFFFF, 16'hFFFF, 0, 1, 63, '1);
		send_item(ACT_ACK, 1, clock_now, 0, 16'hFFFF, 16'h0000, 0, 1, 0, '1);
		send_item(ACT_ACK, 1, clock_now, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, '1);
		send_item(ACT_ACK, 1, clock_now, 0, 16'h0000, 16'hFFFF, 0, 0, 0, '1); // id wraps
		tick_now(1, 1);        // slot now closed: ignored
		tick_now(0, 0);        // client gone
		send_item(ACT_BEGIN, 2, clock_now, 3000, 7, 8, 1, 0, 0, z);
		clock_now += 45001;
		tick_now(2, 1);        // past the timeout
		send_item(ACT_CANCEL, 3, clock_now, 0, 0, 0, 0, 0, 0, z);
		send_item(ACT_CLRALL, 9, clock_now, 0, 0, 0, 0, 0, 0, z);
		send_item(3'd5, 4, clock_now, 0, 0, 0, 0, 0, 0, z);
		send_item(3'd7, 4, clock_now, '1, '1, '1, 1, 1, '1, '1);
		// time wrap, ack bits past the fragment count are dropped
		clock_now = 32'hFFFF_FF00;
		send_item(ACT_BEGIN, 4, clock_now, 2048, 16'h00AA, 16'h0055, 1, 0, 0, z);
		send_item(ACT_ACK, 4, clock_now, 0, 16'h00AA, 16'h0055, 0, 1, 0, 64'h22);
		clock_now = 32'h50;
		tick_now(4, 1);
		send_item(3'd6, 4, clock_now, 0, 0, 0, 0, 0, 0, z);
	endtask

	// walks the registers through their extremes with random traffic
	task automatic test_config_sweep();
		set_regs(50, 5000, 1);
		run_random(50);
		set_regs(8191, 1048575, 64);
		run_random(50);
		set_regs(5000, 600000, 127);   // above 64 acts as 64
		run_random(50);
		set_regs(300, 20000, 0);       // burst zero: ticks send nothing
		run_random(20);
		set_regs(0, 0, 3);
		run_random(40);
		set_regs(250, 45000, 64);
	endtask

	// sink holds off while the source keeps offering items
	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_req = 600;
		run_random(30);
		no_gaps = 1'b0;
	endtask

	// source waits for every result before carrying on
	task automatic test_drain_pause();
		run_random(20);
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_res.size() == 0);
		run_random(40);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		n_items = 0; n_results = 0; n_sends = 0; n_errors = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_req = 0;
		clock_now = '0;
		sb_resend = 250;
		sb_timeout = 45000;
		sb_burst = 64;
		for (int i = 0; i < SLOTS; i++) begin
			sb_active[i] = 1'b0;
			sb_tid[i] = '0;
			sb_tnr[i] = '0;
			sb_nfrags[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_sweep();
		test_backpressure();
		test_drain_pause();
		drain_all();

		$display("covered %0d items and %0d results (%0d fragment sends)",
			n_items, n_results, n_sends);
		$display("register sweep incl. burst zero/over 64, sink hold-off, drain pause");
		if (n_errors == 0 && pending_res.size() == 0) begin
			$display("tb_selective_repeat_fragment_sender: clean");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("tb_selective_repeat_fragment_sender: errors");
		end
		$finish;
	end

endmodule
